FILE: hdl/epd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epd_pkg
// Shared types, constants and the microcode program for the seconds-to-date
// converter.
// ----------------------------------------------------------------------------
package epd_pkg;

    // Step addresses of the microcode program
    localparam int STEP_W = 4;
    typedef logic [STEP_W-1:0] step_t;

    localparam step_t STEP_IDLE     = 4'd0;
    localparam step_t STEP_DIV_DAY  = 4'd1;
    localparam step_t STEP_MOVT     = 4'd2;
    localparam step_t STEP_DIV_ERA  = 4'd3;
    localparam step_t STEP_ERA      = 4'd4;
    localparam step_t STEP_CENT     = 4'd5;
    localparam step_t STEP_DIV_QUAD = 4'd6;
    localparam step_t STEP_QUAD     = 4'd7;
    localparam step_t STEP_YEAR     = 4'd8;
    localparam step_t STEP_MON      = 4'd9;
    localparam step_t STEP_FIXM     = 4'd10;
    localparam step_t STEP_DIV_HOUR = 4'd11;
    localparam step_t STEP_HOUR     = 4'd12;
    localparam step_t STEP_DIV_MIN  = 4'd13;
    localparam step_t STEP_DONE     = 4'd14;

    // Datapath operations
    typedef enum logic [3:0] {
        OP_NOP,
        OP_DIV,     // one restoring-division bit against K << cnt
        OP_MOVT,    // park time of day, form day count from 0000-03-01
        OP_ERA,     // year = 400 * era
        OP_SPAN,    // bounded repeated subtract, add a year span
        OP_MON,     // bounded repeated subtract of month lengths
        OP_QUAD,    // year += 4 * quads
        OP_FIXM,    // day, civil month and year out; restart on time of day
        OP_HOUR,    // hour out
        OP_DONE     // minute, second out, strobe
    } op_t;

    // Constant selection for the subtract unit
    typedef enum logic [2:0] {
        K_DAY,
        K_ERA,
        K_CENT,
        K_QUAD,
        K_YEAR,
        K_HOUR,
        K_MIN,
        K_MONTH
    } ksel_t;

    // Loop condition: jump back to the same step while it holds
    typedef enum logic [1:0] {
        LOOP_NONE,
        LOOP_CNT,   // while count is nonzero
        LOOP_GE     // while count is nonzero and the subtract fits
    } loop_t;

    // One control word
    typedef struct packed {
        op_t        op;
        ksel_t      ksel;
        loop_t      loop;
        logic       cnt_param;   // count comes from the seconds width
        logic [3:0] cnt_init;
        step_t      nxt;
    } ucode_t;

    // Control from sequencer to datapath
    typedef struct packed {
        op_t   op;
        ksel_t ksel;
    } ctrl_t;

    // Constants
    localparam int KW = 18;
    localparam int TW = 17;                         // seconds within a day
    localparam logic [KW-1:0] SECS_PER_DAY   = 18'd86400;
    localparam logic [KW-1:0] DAYS_PER_ERA   = 18'd146097;
    localparam logic [KW-1:0] DAYS_PER_CENT  = 18'd36524;
    localparam logic [KW-1:0] DAYS_PER_QUAD  = 18'd1461;
    localparam logic [KW-1:0] DAYS_PER_YEAR  = 18'd365;
    localparam logic [KW-1:0] SECS_PER_HOUR  = 18'd3600;
    localparam logic [KW-1:0] SECS_PER_MIN   = 18'd60;
    // days from 0000-03-01 to 1970-01-01
    localparam logic [19:0]   EPOCH_DAY_OFS  = 20'd719468;
    localparam logic [15:0]   YEARS_PER_ERA  = 16'd400;
    localparam logic [15:0]   YEARS_PER_CENT = 16'd100;
    // March-based month index of January
    localparam logic [3:0]    MAR_JAN        = 4'd10;
    localparam logic [3:0]    MAR_TO_CIVIL   = 4'd2;

    // Month lengths, March first; February last and never subtracted
    function automatic logic [4:0] month_len_mar(input logic [3:0] m);
        logic [4:0] len;
        unique case (m)
            4'd0:    len = 5'd31;
            4'd1:    len = 5'd30;
            4'd2:    len = 5'd31;
            4'd3:    len = 5'd30;
            4'd4:    len = 5'd31;
            4'd5:    len = 5'd31;
            4'd6:    len = 5'd30;
            4'd7:    len = 5'd31;
            4'd8:    len = 5'd30;
            4'd9:    len = 5'd31;
            4'd10:   len = 5'd31;
            default: len = 5'd29;
        endcase
        return len;
    endfunction

    function automatic logic [KW-1:0] k_value(input ksel_t k, input logic [3:0] m);
        logic [KW-1:0] v;
        unique case (k)
            K_DAY:   v = SECS_PER_DAY;
            K_ERA:   v = DAYS_PER_ERA;
            K_CENT:  v = DAYS_PER_CENT;
            K_QUAD:  v = DAYS_PER_QUAD;
            K_YEAR:  v = DAYS_PER_YEAR;
            K_HOUR:  v = SECS_PER_HOUR;
            K_MIN:   v = SECS_PER_MIN;
            default: v = {{(KW-5){1'b0}}, month_len_mar(m)};
        endcase
        return v;
    endfunction

    function automatic ucode_t uc(input op_t op, input ksel_t k, input loop_t l,
                                  input logic cp, input logic [3:0] ci, input step_t n);
        ucode_t w;
        w.op        = op;
        w.ksel      = k;
        w.loop      = l;
        w.cnt_param = cp;
        w.cnt_init  = ci;
        w.nxt       = n;
        return w;
    endfunction

    // Microcode program
    function automatic ucode_t ucode_rom(input step_t s);
        ucode_t w;
        unique case (s)
            STEP_DIV_DAY:  w = uc(OP_DIV,  K_DAY,   LOOP_CNT,  1'b1, 4'd0,  STEP_MOVT);
            STEP_MOVT:     w = uc(OP_MOVT, K_DAY,   LOOP_NONE, 1'b0, 4'd0,  STEP_DIV_ERA);
            STEP_DIV_ERA:  w = uc(OP_DIV,  K_ERA,   LOOP_CNT,  1'b0, 4'd15, STEP_ERA);
            STEP_ERA:      w = uc(OP_ERA,  K_ERA,   LOOP_NONE, 1'b0, 4'd0,  STEP_CENT);
            STEP_CENT:     w = uc(OP_SPAN, K_CENT,  LOOP_GE,   1'b0, 4'd3,  STEP_DIV_QUAD);
            STEP_DIV_QUAD: w = uc(OP_DIV,  K_QUAD,  LOOP_CNT,  1'b0, 4'd4,  STEP_QUAD);
            STEP_QUAD:     w = uc(OP_QUAD, K_QUAD,  LOOP_NONE, 1'b0, 4'd0,  STEP_YEAR);
            STEP_YEAR:     w = uc(OP_SPAN, K_YEAR,  LOOP_GE,   1'b0, 4'd3,  STEP_MON);
            STEP_MON:      w = uc(OP_MON,  K_MONTH, LOOP_GE,   1'b0, 4'd11, STEP_FIXM);
            STEP_FIXM:     w = uc(OP_FIXM, K_MONTH, LOOP_NONE, 1'b0, 4'd0,  STEP_DIV_HOUR);
            STEP_DIV_HOUR: w = uc(OP_DIV,  K_HOUR,  LOOP_CNT,  1'b0, 4'd4,  STEP_HOUR);
            STEP_HOUR:     w = uc(OP_HOUR, K_HOUR,  LOOP_NONE, 1'b0, 4'd0,  STEP_DIV_MIN);
            STEP_DIV_MIN:  w = uc(OP_DIV,  K_MIN,   LOOP_CNT,  1'b0, 4'd5,  STEP_DONE);
            STEP_DONE:     w = uc(OP_DONE, K_MIN,   LOOP_NONE, 1'b0, 4'd0,  STEP_IDLE);
            default:       w = uc(OP_NOP,  K_DAY,   LOOP_NONE, 1'b0, 4'd0,  STEP_IDLE);
        endcase
        return w;
    endfunction

endpackage

FILE: hdl/epoch_seconds_to_date.sv
`timescale 1ns / 1ps
// Division steps produce one quotient bit per cycle through the shared
// compare-and-subtract unit, followed by the bounded year and month loops;
// the length of the day split grows with SECONDS_BITS.
// Throughput: one transaction at a time; busy is high until the last step.
// Reset: asynchronous, active low; clears the sequencer and the strobe.
// The done strobe lasts one cycle and the receiver cannot stall it.
// ----------------------------------------------------------------------------
// epoch_seconds_to_date
// Converts seconds since 1970-01-01 00:00:00 into Gregorian date and time of
// day with a microcoded sequencer driving a small division datapath.
// ----------------------------------------------------------------------------
module epoch_seconds_to_date #(
    parameter int SECONDS_BITS = 40
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic [SECONDS_BITS-1:0] epoch_seconds,
    output logic                    busy,
    output logic                    done,
    output logic [5:0]              second_of_minute,
    output logic [5:0]              minute_of_hour,
    output logic [4:0]              hour_of_day,
    output logic [4:0]              day_of_month,
    output logic [3:0]              month_index,
    output logic [15:0]             calendar_year
);
    import epd_pkg::*;

    localparam int CNT_W = $clog2(SECONDS_BITS - 16);

    ctrl_t            ctrl;
    logic [CNT_W-1:0] cnt;
    logic             ge;
    logic             accept;

    assign accept = start && !busy;

    epd_sequencer #(
        .SECONDS_BITS (SECONDS_BITS),
        .CNT_W        (CNT_W)
    ) u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .ge    (ge),
        .busy  (busy),
        .ctrl  (ctrl),
        .cnt   (cnt)
    );

    epd_datapath #(
        .SECONDS_BITS (SECONDS_BITS),
        .CNT_W        (CNT_W)
    ) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .load             (accept),
        .epoch_seconds    (epoch_seconds),
        .ctrl             (ctrl),
        .cnt              (cnt),
        .ge               (ge),
        .done             (done),
        .second_of_minute (second_of_minute),
        .minute_of_hour   (minute_of_hour),
        .hour_of_day      (hour_of_day),
        .day_of_month     (day_of_month),
        .month_index      (month_index),
        .calendar_year    (calendar_year)
    );

    // an accepted transaction keeps the block busy
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy)
        else $error("busy not raised after accepted transaction");

    // the strobe comes only after the program has finished
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while busy");

    // one strobe per transaction
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe longer than one cycle");

    // time and date fields stay in range
    a_ranges: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (second_of_minute < 6'd60) && (minute_of_hour < 6'd60) &&
                 (hour_of_day < 5'd24) && (month_index < 4'd12) &&
                 (day_of_month != 5'd0))
        else $error("result field out of range");

endmodule

FILE: hdl/epd_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epd_sequencer
// Step counter, loop counter and conditional jumps over the microcode table.
// ----------------------------------------------------------------------------
module epd_sequencer #(
    parameter int SECONDS_BITS = 40,
    parameter int CNT_W        = 5
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic                 ge,
    output logic                 busy,
    output epd_pkg::ctrl_t       ctrl,
    output logic [CNT_W-1:0]     cnt
);
    import epd_pkg::*;

    // quotient bits of the day split, less one
    localparam logic [CNT_W-1:0] DAY_CNT = CNT_W'(SECONDS_BITS - 17);

    step_t            step_reg, step_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    ucode_t           word;
    logic             stay;

    function automatic logic [CNT_W-1:0] cnt_load(input ucode_t w);
        return w.cnt_param ? DAY_CNT : CNT_W'(w.cnt_init);
    endfunction

    // next step, loop count and busy
    always_comb
    begin
        word      = ucode_rom(step_reg);
        step_next = step_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        unique case (word.loop)
            LOOP_CNT: stay = (cnt_reg != '0);
            LOOP_GE:  stay = (cnt_reg != '0) && ge;
            default:  stay = 1'b0;
        endcase
        if (!busy_reg)
        begin
            if (start)
            begin
                step_next = STEP_DIV_DAY;
                cnt_next  = cnt_load(ucode_rom(STEP_DIV_DAY));
                busy_next = 1'b1;
            end
        end
        else if (stay)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
        else
        begin
            step_next = word.nxt;
            cnt_next  = cnt_load(ucode_rom(word.nxt));
            busy_next = (word.nxt != STEP_IDLE);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= STEP_IDLE;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
        end
    end

    assign busy      = busy_reg;
    assign cnt       = cnt_reg;
    assign ctrl.op   = busy_reg ? word.op : OP_NOP;
    assign ctrl.ksel = word.ksel;

endmodule

FILE: hdl/epd_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epd_datapath
// Remainder and quotient registers around one shifted compare-and-subtract
// unit, plus year/month accumulators and the result registers.
// ----------------------------------------------------------------------------
module epd_datapath #(
    parameter int SECONDS_BITS = 40,
    parameter int CNT_W        = 5
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    load,
    input  logic [SECONDS_BITS-1:0] epoch_seconds,
    input  epd_pkg::ctrl_t          ctrl,
    input  logic [CNT_W-1:0]        cnt,
    output logic                    ge,
    output logic                    done,
    output logic [5:0]              second_of_minute,
    output logic [5:0]              minute_of_hour,
    output logic [4:0]              hour_of_day,
    output logic [4:0]              day_of_month,
    output logic [3:0]              month_index,
    output logic [15:0]             calendar_year
);
    import epd_pkg::*;

    // remainder holds the seconds or the day count from 0000-03-01; at least 33 bits
    localparam int AW = (SECONDS_BITS > 33) ? SECONDS_BITS : 33;
    localparam int QW = SECONDS_BITS - 16;

    logic [AW-1:0]    a_reg;
    logic [QW-1:0]    q_reg;
    logic [TW-1:0]    t_reg;
    logic [15:0]      y_reg;
    logic [3:0]       m_reg;
    logic             done_reg;
    logic [5:0]       sec_reg, min_reg;
    logic [4:0]       hour_reg, day_reg;
    logic [3:0]       mon_reg;
    logic [15:0]      year_reg;

    logic [KW-1:0]    kval;
    logic [CNT_W-1:0] shift;
    logic [AW-1:0]    kshift;
    logic [AW-1:0]    diff;
    logic             take;
    logic             late;
    logic [3:0]       civil;
    logic [15:0]      span;

    // shifted divisor never exceeds AW bits for any step of the program
    always_comb
    begin
        kval   = k_value(ctrl.ksel, m_reg);
        shift  = (ctrl.op == OP_DIV) ? cnt : '0;
        kshift = {{(AW-KW){1'b0}}, kval} << shift;
        ge     = (a_reg >= kshift);
        diff   = a_reg - kshift;
        take   = ge && (cnt != '0);
        late   = (m_reg >= MAR_JAN);
        civil  = late ? (m_reg - MAR_JAN) : (m_reg + MAR_TO_CIVIL);
        span   = (ctrl.ksel == K_CENT) ? YEARS_PER_CENT : 16'd1;
    end

    // working registers and results
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            a_reg <= AW'(epoch_seconds);
            q_reg <= '0;
            m_reg <= '0;
        end
        else
        begin
            unique case (ctrl.op)
                OP_DIV:
                begin
                    q_reg <= {q_reg[QW-2:0], ge};
                    if (ge)
                        a_reg <= diff;
                end
                OP_MOVT:
                begin
                    t_reg <= a_reg[TW-1:0];
                    a_reg <= AW'(q_reg) + AW'(EPOCH_DAY_OFS);
                    q_reg <= '0;
                end
                OP_ERA:
                begin
                    y_reg <= q_reg[15:0] * YEARS_PER_ERA;
                    q_reg <= '0;
                end
                OP_SPAN:
                begin
                    if (take)
                    begin
                        a_reg <= diff;
                        y_reg <= y_reg + span;
                    end
                end
                OP_MON:
                begin
                    if (take)
                    begin
                        a_reg <= diff;
                        m_reg <= m_reg + 4'd1;
                    end
                end
                OP_QUAD:
                begin
                    y_reg <= y_reg + {q_reg[13:0], 2'b00};
                    q_reg <= '0;
                end
                OP_FIXM:
                begin
                    day_reg  <= a_reg[4:0] + 5'd1;
                    mon_reg  <= civil;
                    year_reg <= y_reg + {15'd0, late};
                    a_reg    <= AW'(t_reg);
                    q_reg    <= '0;
                end
                OP_HOUR:
                begin
                    hour_reg <= q_reg[4:0];
                    q_reg    <= '0;
                end
                OP_DONE:
                begin
                    min_reg <= q_reg[5:0];
                    sec_reg <= a_reg[5:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    // result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= (ctrl.op == OP_DONE);
    end

    assign done             = done_reg;
    assign second_of_minute = sec_reg;
    assign minute_of_hour   = min_reg;
    assign hour_of_day      = hour_reg;
    assign day_of_month     = day_reg;
    assign month_index      = mon_reg;
    assign calendar_year    = year_reg;

endmodule

FILE: sim/epd_date_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epd_date_checker
// Watches the start/busy and done channels of the seconds-to-date converter.
// It computes the civil date of every accepted transaction with its own
// calendar arithmetic, queues it, and compares each done strobe field by
// field against the oldest queued date.
// ----------------------------------------------------------------------------
module epd_date_checker #(
    parameter int SECONDS_BITS = 40
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic                    busy,
    input  logic [SECONDS_BITS-1:0] epoch_seconds,
    input  logic                    done,
    input  logic [5:0]              second_of_minute,
    input  logic [5:0]              minute_of_hour,
    input  logic [4:0]              hour_of_day,
    input  logic [4:0]              day_of_month,
    input  logic [3:0]              month_index,
    input  logic [15:0]             calendar_year,
    output int                      errors,
    output int                      checked,
    output int                      pending
);

    localparam longint unsigned SECS_PER_MINUTE = 60;
    localparam longint unsigned SECS_PER_HOUR   = 3600;
    localparam longint unsigned SECS_PER_DAY    = 86400;
    localparam longint unsigned DAYS_PER_ERA    = 146097;
    localparam longint unsigned YEARS_PER_ERA   = 400;
    localparam longint unsigned FIRST_YEAR      = 1970;
    localparam int              REPORT_LIMIT    = 40;

    // Month indexes with short lengths
    localparam int unsigned MONTH_FEB = 1;
    localparam int unsigned MONTH_APR = 3;
    localparam int unsigned MONTH_JUN = 5;
    localparam int unsigned MONTH_SEP = 8;
    localparam int unsigned MONTH_NOV = 10;
    localparam int unsigned MONTH_DEC = 11;

    typedef struct packed {
        logic [5:0]  second;
        logic [5:0]  minute;
        logic [4:0]  hour;
        logic [4:0]  day;
        logic [3:0]  month;
        logic [15:0] year;
    } civil_t;

    civil_t expected_dates[$];
    civil_t oldest;
    int     mismatch_n;
    int     checked_n;

    function automatic bit is_leap(input longint unsigned y);
        if (y % 400 == 0)
            return 1'b1;
        if (y % 100 == 0)
            return 1'b0;
        return (y % 4 == 0);
    endfunction

    function automatic longint unsigned days_in_year(input longint unsigned y);
        return is_leap(y) ? 366 : 365;
    endfunction

    function automatic longint unsigned days_in_month(input int unsigned m, input bit leap);
        case (m)
            MONTH_FEB:                                return leap ? 29 : 28;
            MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: return 30;
            default:                                  return 31;
        endcase
    endfunction

    // Seconds since the epoch to civil date: whole days, 400-year eras,
    // single years, then months
    function automatic civil_t to_civil(input logic [SECONDS_BITS-1:0] secs);
        civil_t            r;
        longint unsigned   s;
        longint unsigned   tod;
        longint unsigned   days;
        longint unsigned   yr;
        int unsigned       mon;
        bit                leap;
        s    = secs;
        tod  = s % SECS_PER_DAY;
        days = s / SECS_PER_DAY;
        yr   = FIRST_YEAR + YEARS_PER_ERA * (days / DAYS_PER_ERA);
        days = days % DAYS_PER_ERA;
        while (days >= days_in_year(yr)) begin
            days -= days_in_year(yr);
            yr++;
        end
        leap = is_leap(yr);
        mon  = 0;
        while (mon < MONTH_DEC && days >= days_in_month(mon, leap)) begin
            days -= days_in_month(mon, leap);
            mon++;
        end
        r.second = 6'(tod % SECS_PER_MINUTE);
        r.minute = 6'((tod % SECS_PER_HOUR) / SECS_PER_MINUTE);
        r.hour   = 5'(tod / SECS_PER_HOUR);
        r.day    = 5'(days + 1);
        r.month  = 4'(mon);
        r.year   = 16'(yr);
        return r;
    endfunction

    task automatic check_field(input string name, input longint unsigned want,
                               input longint unsigned got);
        if (want != got) begin
            mismatch_n++;
            if (mismatch_n <= REPORT_LIMIT)
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            else if (mismatch_n == REPORT_LIMIT + 1)
                $display("%0t: further mismatches not shown", $time);
        end
    endtask

    // Done is handled before a same-edge start: the strobe belongs to
    // the transaction already in flight
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            expected_dates.delete();
            pending <= 0;
        end
        else begin
            if (done) begin
                if (expected_dates.size() == 0) begin
                    mismatch_n++;
                    $display("%0t: result with no transaction pending, year %0d",
                             $time, calendar_year);
                end
                else begin
                    oldest = expected_dates.pop_front();
                    check_field("second_of_minute", oldest.second, second_of_minute);
                    check_field("minute_of_hour",   oldest.minute, minute_of_hour);
                    check_field("hour_of_day",      oldest.hour,   hour_of_day);
                    check_field("day_of_month",     oldest.day,    day_of_month);
                    check_field("month_index",      oldest.month,  month_index);
                    check_field("calendar_year",    oldest.year,   calendar_year);
                    checked_n++;
                end
            end
            if (start && !busy)
                expected_dates.push_back(to_civil(epoch_seconds));
            pending <= expected_dates.size();
        end
    end

    // Counters published through registers so readers never race the update
    always @(posedge clk) begin
        errors  <= mismatch_n;
        checked <= checked_n;
    end

endmodule

FILE: sim/tb_epoch_seconds_to_date.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_epoch_seconds_to_date
// Drives the seconds-to-date converter with directed edge cases (time of day
// limits, year ends, leap days, century and 400-year boundaries, full range)
// and then random seconds spread over the whole range and around year and
// month starts, with random gaps between transactions. A checker beside the
// block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_epoch_seconds_to_date;

    localparam int              SECONDS_BITS = 40;
    localparam int              RANDOM_ITEMS = 1900;
    localparam int              QUIET_LIMIT  = 2000;
    localparam int              DRAIN_CYCLES = 120;
    localparam int              BURST_RUN    = 50;
    localparam int              MAX_GAP      = 8;
    localparam longint unsigned SECS_PER_DAY = 86400;
    localparam longint unsigned DAYS_PER_ERA = 146097;
    localparam int unsigned     FIRST_YEAR   = 1970;
    localparam int unsigned     LAST_YEAR    = 36811;

    // Random stimulus kinds
    typedef enum int unsigned {
        KIND_FULL,
        KIND_LOW32,
        KIND_YEAR,
        KIND_DAY
    } stim_kind_t;

    logic                    clk           = 1'b0;
    logic                    rst_n         = 1'b0;
    logic                    start         = 1'b0;
    logic [SECONDS_BITS-1:0] epoch_seconds = '0;
    logic                    busy;
    logic                    done;
    logic [5:0]              second_of_minute;
    logic [5:0]              minute_of_hour;
    logic [4:0]              hour_of_day;
    logic [4:0]              day_of_month;
    logic [3:0]              month_index;
    logic [15:0]             calendar_year;

    int fail_count;
    int compared;
    int outstanding;
    int quiet_cycles = 0;
    int directed_n   = 0;
    bit burst        = 1'b0;

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    epoch_seconds_to_date #(
        .SECONDS_BITS(SECONDS_BITS)
    ) uut (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .epoch_seconds    (epoch_seconds),
        .busy             (busy),
        .done             (done),
        .second_of_minute (second_of_minute),
        .minute_of_hour   (minute_of_hour),
        .hour_of_day      (hour_of_day),
        .day_of_month     (day_of_month),
        .month_index      (month_index),
        .calendar_year    (calendar_year)
    );

    epd_date_checker #(
        .SECONDS_BITS(SECONDS_BITS)
    ) checker_i (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .busy             (busy),
        .epoch_seconds    (epoch_seconds),
        .done             (done),
        .second_of_minute (second_of_minute),
        .minute_of_hour   (minute_of_hour),
        .hour_of_day      (hour_of_day),
        .day_of_month     (day_of_month),
        .month_index      (month_index),
        .calendar_year    (calendar_year),
        .errors           (fail_count),
        .checked          (compared),
        .pending          (outstanding)
    );

    // Watchdog: no accepted transaction and no result for too long
    always @(posedge clk) begin
        if (!rst_n || (start && !busy) || done)
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: watchdog expired", $time);
            $display("== FAIL ==");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    function automatic logic [SECONDS_BITS-1:0] any_seconds();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return r[SECONDS_BITS-1:0];
    endfunction

    // Days from the epoch to January 1 of year y
    function automatic longint unsigned days_to_jan1(input int unsigned y);
        longint unsigned n;
        n = y - 1;
        return 365 * (y - FIRST_YEAR) + n / 4 - n / 100 + n / 400 - 477;
    endfunction

    // One transaction: optional gap with start low and noise on the data,
    // then hold start until the block takes it
    task automatic send_seconds(input logic [SECONDS_BITS-1:0] value);
        int gap;
        gap = burst ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            start         <= 1'b0;
            epoch_seconds <= any_seconds();
            repeat (gap) @(posedge clk);
        end
        start         <= 1'b1;
        epoch_seconds <= value;
        do
            @(posedge clk);
        while (busy);
    endtask

    initial begin
        logic [SECONDS_BITS-1:0] edge_cases[$];
        longint unsigned         v;
        int unsigned             y;
        stim_kind_t              kind;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: time of day limits, year ends, leap days, centuries,
        // era boundary, 32-bit rollover and the top of the range
        edge_cases.push_back('0);
        edge_cases.push_back(SECONDS_BITS'(59));
        edge_cases.push_back(SECONDS_BITS'(60));
        edge_cases.push_back(SECONDS_BITS'(3599));
        edge_cases.push_back(SECONDS_BITS'(3600));
        edge_cases.push_back(SECONDS_BITS'(SECS_PER_DAY - 1));
        edge_cases.push_back(SECONDS_BITS'(SECS_PER_DAY));
        edge_cases.push_back(SECONDS_BITS'(days_to_jan1(1971) * SECS_PER_DAY - 1));
        edge_cases.push_back(SECONDS_BITS'(days_to_jan1(1971) * SECS_PER_DAY));
        edge_cases.push_back(SECONDS_BITS'((days_to_jan1(1972) + 59) * SECS_PER_DAY));
        edge_cases.push_back(SECONDS_BITS'((days_to_jan1(1972) + 60) * SECS_PER_DAY - 1));
        edge_cases.push_back(SECONDS_BITS'(days_to_jan1(1973) * SECS_PER_DAY - 1));
        edge_cases.push_back(SECONDS_BITS'((days_to_jan1(2000) + 59) * SECS_PER_DAY));
        edge_cases.push_back(SECONDS_BITS'((days_to_jan1(2000) + 60) * SECS_PER_DAY));
        edge_cases.push_back(SECONDS_BITS'((days_to_jan1(2100) + 59) * SECS_PER_DAY - 1));
        edge_cases.push_back(SECONDS_BITS'((days_to_jan1(2100) + 59) * SECS_PER_DAY));
        edge_cases.push_back(SECONDS_BITS'((days_to_jan1(2400) + 59) * SECS_PER_DAY));
        edge_cases.push_back(SECONDS_BITS'((days_to_jan1(2400) + 60) * SECS_PER_DAY - 1));
        edge_cases.push_back(SECONDS_BITS'(DAYS_PER_ERA * SECS_PER_DAY - 1));
        edge_cases.push_back(SECONDS_BITS'(DAYS_PER_ERA * SECS_PER_DAY));
        edge_cases.push_back(SECONDS_BITS'(64'hFFFF_FFFF));
        edge_cases.push_back(SECONDS_BITS'(64'h1_0000_0000));
        edge_cases.push_back({1'b1, {(SECONDS_BITS-1){1'b0}}});
        edge_cases.push_back(SECONDS_BITS'(64'hAA_AAAA_AAAA));
        edge_cases.push_back(SECONDS_BITS'(64'h55_5555_5555));
        edge_cases.push_back('1);
        foreach (edge_cases[i])
            send_seconds(edge_cases[i]);
        directed_n = edge_cases.size();

        // Random: full range, 32-bit range, around year and month starts,
        // and around midnight
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i % BURST_RUN == 0)
                burst = ($urandom_range(0, 3) == 0);
            case ($urandom_range(0, 9))
                0, 1, 2: kind = KIND_FULL;
                3, 4:    kind = KIND_LOW32;
                5, 6, 7: kind = KIND_YEAR;
                default: kind = KIND_DAY;
            endcase
            case (kind)
                KIND_FULL:  v = any_seconds();
                KIND_LOW32: v = $urandom;
                KIND_YEAR: begin
                    y = $urandom_range(FIRST_YEAR, LAST_YEAR);
                    v = (days_to_jan1(y) + $urandom_range(0, 365)) * SECS_PER_DAY;
                    case ($urandom_range(0, 2))
                        0:       v = v + $urandom_range(0, SECS_PER_DAY - 1);
                        1:       v = v - 1;
                        default: v = v;
                    endcase
                end
                default: begin
                    v = longint'($urandom_range(0, 12725829)) * SECS_PER_DAY;
                    v = ($urandom_range(0, 1) == 0) ? v : v + SECS_PER_DAY - 1;
                end
            endcase
            send_seconds(SECONDS_BITS'(v));
        end

        // Drain: every result in, then idle clocks with start low
        start <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Converted %0d seconds values (%0d directed, %0d random) with %0d checked.",
                 directed_n + RANDOM_ITEMS, directed_n, RANDOM_ITEMS, compared);
        $display("Covered full 40-bit range, leap and century years, month and midnight edges.");
        if (fail_count == 0 && outstanding == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
